// ===== sv/small_language_token_scanner_unit_assert.svh =====
// Assertion macros for the token scanner checker.
// Used by the checker file only; no other dependencies.
`ifndef SMALL_LANGUAGE_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define SMALL_LANGUAGE_TOKEN_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SLTSU_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("token scanner check failed");

// Next-cycle implication, disabled while reset is high.
`define SLTSU_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("token scanner check failed");

`endif

// ===== sv/sltsu_pkg.sv =====
// Shared types, token codes and keyword tables for the token scanner.
// No dependencies; used by every module of the block.
`default_nettype none

package sltsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  // Token type codes
  localparam logic [3:0] TYPE_END     = 4'd0;
  localparam logic [3:0] TYPE_LPAREN  = 4'd1;
  localparam logic [3:0] TYPE_RPAREN  = 4'd2;
  localparam logic [3:0] TYPE_LBRACE  = 4'd3;
  localparam logic [3:0] TYPE_RBRACE  = 4'd4;
  localparam logic [3:0] TYPE_COLON   = 4'd5;
  localparam logic [3:0] TYPE_SEMI    = 4'd6;
  localparam logic [3:0] TYPE_COMMA   = 4'd7;
  localparam logic [3:0] TYPE_EQUAL   = 4'd8;
  localparam logic [3:0] TYPE_STRING  = 4'd9;
  localparam logic [3:0] TYPE_LET     = 4'd10;
  localparam logic [3:0] TYPE_FN      = 4'd11;
  localparam logic [3:0] TYPE_RETURN  = 4'd12;
  localparam logic [3:0] TYPE_INTEGER = 4'd13;
  localparam logic [3:0] TYPE_IDENT   = 4'd14;

  // Keyword lengths
  localparam logic [2:0] KW_LEN_LET    = 3'd3;
  localparam logic [2:0] KW_LEN_FN     = 3'd2;
  localparam logic [2:0] KW_LEN_RETURN = 3'd6;
  localparam logic [2:0] WORD_LEN_MAX  = 3'd7;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  // Classified source byte, as queued between front and back
  typedef struct packed {
    logic       end_flag;
    logic       is_space;
    logic       is_quote;
    logic       is_word;
    logic       is_digit;
    logic [3:0] punct;     // punctuation token type, TYPE_END if none
    logic [7:0] data;
  } cls_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cls_t item;
  } head_t;

  // One result item
  typedef struct packed {
    logic [3:0] token_type;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       token_last;
  } res_t;

  // Bit k set when byte c matches keyword k at position pos
  // (bit0 let, bit1 fn, bit2 return).
  function automatic logic [2:0] kw_match(input logic [7:0] c, input logic [2:0] pos);
    logic [2:0] m;
    case (pos)
      3'd0: m = {c == 8'h72, c == 8'h66, c == 8'h6C};  // r f l
      3'd1: m = {c == 8'h65, c == 8'h6E, c == 8'h65};  // e n e
      3'd2: m = {c == 8'h74, 1'b0,       c == 8'h74};  // t - t
      3'd3: m = {c == 8'h75, 1'b0,       1'b0};        // u
      3'd4: m = {c == 8'h72, 1'b0,       1'b0};        // r
      3'd5: m = {c == 8'h6E, 1'b0,       1'b0};        // n
      default: m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sltsu_front.sv =====
// Front end: accepts source bytes and classifies them for the back end.
// Depends on sltsu_pkg.
`default_nettype none

module sltsu_front (
  input  wire logic              push,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_input,
  input  wire logic              queue_full,
  output logic                   full,
  output logic                   wr_en,
  output sltsu_pkg::cls_t        wr_item
);

  logic [3:0] punct;

  always_comb begin
    case (in_byte)
      8'h28:   punct = sltsu_pkg::TYPE_LPAREN;
      8'h29:   punct = sltsu_pkg::TYPE_RPAREN;
      8'h7B:   punct = sltsu_pkg::TYPE_LBRACE;
      8'h7D:   punct = sltsu_pkg::TYPE_RBRACE;
      8'h3A:   punct = sltsu_pkg::TYPE_COLON;
      8'h3B:   punct = sltsu_pkg::TYPE_SEMI;
      8'h2C:   punct = sltsu_pkg::TYPE_COMMA;
      8'h3D:   punct = sltsu_pkg::TYPE_EQUAL;
      default: punct = sltsu_pkg::TYPE_END;
    endcase
  end

  always_comb begin
    wr_item.end_flag = end_of_input;
    wr_item.is_space = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    wr_item.is_quote = (in_byte == sltsu_pkg::CHAR_QUOTE);
    wr_item.is_digit = (in_byte >= 8'h30 && in_byte <= 8'h39);
    wr_item.is_word  = wr_item.is_digit
                    || (in_byte >= 8'h61 && in_byte <= 8'h7A)
                    || (in_byte >= 8'h41 && in_byte <= 8'h5A)
                    || (in_byte == 8'h5F);
    wr_item.punct    = punct;
    wr_item.data     = in_byte;
  end

  assign full  = queue_full;
  assign wr_en = push && !queue_full;

endmodule

`default_nettype wire

// ===== sv/sltsu_queue.sv =====
// Short queue of classified bytes between front and back end.
// Depends on sltsu_pkg.
`default_nettype none

module sltsu_queue #(
  parameter int DEPTH = sltsu_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire sltsu_pkg::cls_t wr_item,
  input  wire logic            rd_en,
  output logic                 full,
  output sltsu_pkg::head_t     head
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(DEPTH);

  sltsu_pkg::cls_t   mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_rd;

  assign full       = (count == COUNT_FULL);
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];
  assign do_rd      = rd_en && head.valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(do_rd);
    end
  end

endmodule

`default_nettype wire

// ===== sv/sltsu_back.sv =====
// Back end: scanner state machine and result output stage.
// Depends on sltsu_pkg.
`default_nettype none

module sltsu_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sltsu_pkg::head_t head,
  output logic                  rd_en,
  output logic                  empty,
  input  wire logic             pop,
  output logic [3:0]            token_type,
  output logic [7:0]            value_byte,
  output logic                  has_byte,
  output logic                  token_last
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_WORD
  } mode_t;

  mode_t           mode;
  logic [2:0]      word_length;
  logic            starts_with_digit;
  logic [2:0]      keyword_candidates;

  sltsu_pkg::res_t out_res;
  logic            out_valid;
  sltsu_pkg::res_t pend_res;
  logic            pend_valid;

  mode_t           mode_next;
  logic [2:0]      word_length_next;
  logic            starts_with_digit_next;
  logic [2:0]      keyword_candidates_next;
  sltsu_pkg::res_t res0;
  sltsu_pkg::res_t res1;
  logic [1:0]      n_res;

  sltsu_pkg::cls_t it;
  logic            out_free;
  logic            take;
  logic [3:0]      word_type;

  assign it       = head.item;
  assign out_free = !out_valid || pop;
  assign take     = head.valid && !pend_valid && out_free;
  assign rd_en    = take;

  always_comb begin
    if (keyword_candidates[0] && word_length == sltsu_pkg::KW_LEN_LET) begin
      word_type = sltsu_pkg::TYPE_LET;
    end else if (keyword_candidates[1] && word_length == sltsu_pkg::KW_LEN_FN) begin
      word_type = sltsu_pkg::TYPE_FN;
    end else if (keyword_candidates[2] && word_length == sltsu_pkg::KW_LEN_RETURN) begin
      word_type = sltsu_pkg::TYPE_RETURN;
    end else begin
      word_type = starts_with_digit ? sltsu_pkg::TYPE_INTEGER : sltsu_pkg::TYPE_IDENT;
    end
  end

  always_comb begin
    sltsu_pkg::res_t idle_res;
    sltsu_pkg::res_t close_word;
    sltsu_pkg::res_t close_str;
    sltsu_pkg::res_t end_res;
    logic            idle_has;
    mode_t           idle_mode;
    logic [2:0]      idle_len;
    logic            idle_dig;
    logic [2:0]      idle_cand;

    close_word = '{word_type, 8'h00, 1'b0, 1'b1};
    close_str  = '{sltsu_pkg::TYPE_STRING, 8'h00, 1'b0, 1'b1};
    end_res    = '{sltsu_pkg::TYPE_END, 8'h00, 1'b0, 1'b1};

    // byte handled between tokens, from the idle state
    idle_has  = 1'b0;
    idle_res  = '{sltsu_pkg::TYPE_END, 8'h00, 1'b0, 1'b0};
    idle_mode = MODE_IDLE;
    idle_len  = '0;
    idle_dig  = 1'b0;
    idle_cand = 3'b111;
    if (it.is_space) begin
      idle_has = 1'b0;
    end else if (it.punct != sltsu_pkg::TYPE_END) begin
      idle_has = 1'b1;
      idle_res = '{it.punct, it.data, 1'b1, 1'b1};
    end else if (it.is_quote) begin
      idle_mode = MODE_STRING;
    end else begin
      idle_has  = 1'b1;
      idle_res  = '{sltsu_pkg::TYPE_END, it.data, 1'b1, 1'b0};
      idle_mode = MODE_WORD;
      idle_len  = 3'd1;
      idle_dig  = it.is_digit;
      idle_cand = sltsu_pkg::kw_match(it.data, 3'd0);
    end

    mode_next               = mode;
    word_length_next        = word_length;
    starts_with_digit_next  = starts_with_digit;
    keyword_candidates_next = keyword_candidates;
    res0  = idle_res;
    res1  = end_res;
    n_res = 2'd0;

    if (it.end_flag) begin
      case (mode)
        MODE_WORD: begin
          res0  = close_word;
          n_res = 2'd2;
        end
        MODE_STRING: begin
          res0  = close_str;
          n_res = 2'd2;
        end
        default: begin
          res0  = end_res;
          n_res = 2'd1;
        end
      endcase
      mode_next               = MODE_IDLE;
      word_length_next        = '0;
      starts_with_digit_next  = 1'b0;
      keyword_candidates_next = 3'b111;
    end else if (mode == MODE_STRING) begin
      n_res = 2'd1;
      if (it.is_quote) begin
        res0                    = close_str;
        mode_next               = MODE_IDLE;
        word_length_next        = '0;
        starts_with_digit_next  = 1'b0;
        keyword_candidates_next = 3'b111;
      end else begin
        res0 = '{sltsu_pkg::TYPE_STRING, it.data, 1'b1, 1'b0};
      end
    end else if (mode == MODE_WORD && it.is_word) begin
      // extend the open word
      n_res = 2'd1;
      res0  = '{sltsu_pkg::TYPE_END, it.data, 1'b1, 1'b0};
      keyword_candidates_next = keyword_candidates
                              & sltsu_pkg::kw_match(it.data, word_length);
      if (word_length != sltsu_pkg::WORD_LEN_MAX) begin
        word_length_next = word_length + 3'd1;
      end
    end else begin
      // close an open word first, then handle the byte between tokens
      if (mode == MODE_WORD) begin
        res0  = close_word;
        res1  = idle_res;
        n_res = idle_has ? 2'd2 : 2'd1;
      end else begin
        res0  = idle_res;
        n_res = idle_has ? 2'd1 : 2'd0;
      end
      mode_next               = idle_mode;
      word_length_next        = idle_len;
      starts_with_digit_next  = idle_dig;
      keyword_candidates_next = idle_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      word_length        <= '0;
      starts_with_digit  <= 1'b0;
      keyword_candidates <= 3'b111;
      out_valid          <= 1'b0;
      pend_valid         <= 1'b0;
    end else begin
      if (pend_valid && out_free) begin
        // drain the second result of the previous item
        out_res    <= pend_res;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (take) begin
        mode               <= mode_next;
        word_length        <= word_length_next;
        starts_with_digit  <= starts_with_digit_next;
        keyword_candidates <= keyword_candidates_next;
        if (n_res != 2'd0) begin
          out_res <= res0;
        end
        // the output stage is free here: load it or leave it empty
        out_valid  <= (n_res != 2'd0);
        pend_res   <= res1;
        pend_valid <= (n_res == 2'd2);
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty      = !out_valid;
  assign token_type = out_res.token_type;
  assign value_byte = out_res.value_byte;
  assign has_byte   = out_res.has_byte;
  assign token_last = out_res.token_last;

endmodule

`default_nettype wire

// ===== sv/small_language_token_scanner_unit.sv =====
// Top level of the streaming token scanner: front end, queue, back end.
// Depends on sltsu_pkg, sltsu_front, sltsu_queue and sltsu_back.
//
//   channel   handshake          fields
//   -------   ----------------   ------------------------------------------------
//   input     push / full        in_byte[7:0], end_of_input
//   result    empty / pop        token_type[3:0], value_byte[7:0], has_byte, token_last
//
// Cycles: one byte is accepted per cycle while full is low. The back end
// retires one queued byte per cycle while its output stage is free; a byte
// that yields two results (a word closed by punctuation or by a new word, or
// end of input closing a token) holds the back end while its second result
// drains. The first result of a byte passes through the queue and then the
// output stage register before it reaches the result ports.
// Reset (rst, synchronous) empties the queue and the output stage and
// returns the scanner to the between-tokens state.
// A stalled result side fills the queue, which then raises full.
`default_nettype none

module small_language_token_scanner_unit #(
  parameter int QUEUE_DEPTH = sltsu_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      token_type,
  output logic [7:0]      value_byte,
  output logic            has_byte,
  output logic            token_last
);

  logic             queue_full;
  logic             wr_en;
  sltsu_pkg::cls_t  wr_item;
  logic             rd_en;
  sltsu_pkg::head_t head;

  // Classify each accepted byte and push it into the queue.
  sltsu_front u_front (
    .push         (push),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .queue_full   (queue_full),
    .full         (full),
    .wr_en        (wr_en),
    .wr_item      (wr_item)
  );

  // Decouple the front end from result stalls.
  sltsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (rd_en),
    .full    (queue_full),
    .head    (head)
  );

  // Run the scanner state machine and present results.
  sltsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .rd_en      (rd_en),
    .empty      (empty),
    .pop        (pop),
    .token_type (token_type),
    .value_byte (value_byte),
    .has_byte   (has_byte),
    .token_last (token_last)
  );

endmodule

`default_nettype wire

// ===== sv/sltsu_checker.sv =====
// Port-level checks on the token scanner result side, bound to the top level.
// Depends on small_language_token_scanner_unit_assert.svh and sltsu_pkg.
`default_nettype none

`include "small_language_token_scanner_unit_assert.svh"

module sltsu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [3:0] token_type,
  input wire logic [7:0] value_byte,
  input wire logic       has_byte,
  input wire logic       token_last
);

  // A result that is not taken stays in place.
  `SLTSU_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(token_type) && $stable(value_byte) && $stable(has_byte) && $stable(token_last))

  // Results without a value byte close a token and carry a zero byte.
  `SLTSU_ASSERT_NOW(a_close_zero, clk, rst, !empty && !has_byte, token_last && value_byte == 8'd0)

  // Word bytes of untyped words never close a token.
  `SLTSU_ASSERT_NOW(a_word_open, clk, rst, !empty && has_byte && token_type == sltsu_pkg::TYPE_END, !token_last)

  // Type fifteen is never produced.
  `SLTSU_ASSERT_NOW(a_type_range, clk, rst, !empty, token_type != 4'd15)

endmodule

bind small_language_token_scanner_unit sltsu_checker u_sltsu_checker (.*);

`default_nettype wire

// ===== sim/small_language_token_scanner_unit_checker.sv =====
// Result checker for the token scanner: tracks scanner state from accepted
// source bytes, queues the tokens it predicts and compares each popped result.
// Depends on sltsu_pkg for the token codes and the result layout.

module small_language_token_scanner_unit_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [3:0] token_type,
  input  wire logic [7:0] value_byte,
  input  wire logic       has_byte,
  input  wire logic       token_last,
  output int              failures,
  output int              outstanding,
  output int              checked
);

  typedef enum logic [1:0] {
    SCAN_BETWEEN = 2'd0,
    SCAN_STRING  = 2'd1,
    SCAN_WORD    = 2'd2
  } scan_mode_t;

  scan_mode_t mode;
  logic [2:0] word_len;
  logic       digit_lead;
  logic [2:0] kw_alive;   // bit0 let, bit1 fn, bit2 return

  sltsu_pkg::res_t expected_tokens[$];
  int   fail_count = 0;
  int   match_count = 0;

  function automatic logic [7:0] keyword_char(input int k, input logic [2:0] pos);
    logic [47:0] text;
    case (k)
      0: text = {"let", 24'd0};
      1: text = {"fn", 32'd0};
      default: text = "return";
    endcase
    return text[47 - 8 * pos -: 8];
  endfunction

  function automatic logic [2:0] keyword_len(input int k);
    case (k)
      0: return sltsu_pkg::KW_LEN_LET;
      1: return sltsu_pkg::KW_LEN_FN;
      default: return sltsu_pkg::KW_LEN_RETURN;
    endcase
  endfunction

  function automatic logic [3:0] punct_code(input logic [7:0] c);
    case (c)
      "(": return sltsu_pkg::TYPE_LPAREN;
      ")": return sltsu_pkg::TYPE_RPAREN;
      "{": return sltsu_pkg::TYPE_LBRACE;
      "}": return sltsu_pkg::TYPE_RBRACE;
      ":": return sltsu_pkg::TYPE_COLON;
      ";": return sltsu_pkg::TYPE_SEMI;
      ",": return sltsu_pkg::TYPE_COMMA;
      "=": return sltsu_pkg::TYPE_EQUAL;
      default: return sltsu_pkg::TYPE_END;
    endcase
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit continues_word(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [3:0] closed_word_type();
    if (kw_alive[0] && word_len == sltsu_pkg::KW_LEN_LET) return sltsu_pkg::TYPE_LET;
    if (kw_alive[1] && word_len == sltsu_pkg::KW_LEN_FN) return sltsu_pkg::TYPE_FN;
    if (kw_alive[2] && word_len == sltsu_pkg::KW_LEN_RETURN) return sltsu_pkg::TYPE_RETURN;
    return digit_lead ? sltsu_pkg::TYPE_INTEGER : sltsu_pkg::TYPE_IDENT;
  endfunction

  task automatic clear_scan();
    mode       = SCAN_BETWEEN;
    word_len   = 3'd0;
    digit_lead = 1'b0;
    kw_alive   = 3'b111;
  endtask

  task automatic add_token(input logic [3:0] t, input logic [7:0] b, input logic h,
                           input logic l);
    sltsu_pkg::res_t r;
    r.token_type = t;
    r.value_byte = b;
    r.has_byte   = h;
    r.token_last = l;
    expected_tokens.push_back(r);
  endtask

  task automatic grow_word(input logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (word_len >= keyword_len(k) || keyword_char(k, word_len) != c) kw_alive[k] = 1'b0;
    end
    if (word_len != sltsu_pkg::WORD_LEN_MAX) word_len = word_len + 3'd1;
  endtask

  // Byte seen between tokens: punctuation, blank, string open or word start.
  task automatic open_token(input logic [7:0] c);
    logic [3:0] p;
    p = punct_code(c);
    if (is_blank(c)) begin
      mode = SCAN_BETWEEN;
    end else if (p != sltsu_pkg::TYPE_END) begin
      add_token(p, c, 1'b1, 1'b1);
    end else if (c == sltsu_pkg::CHAR_QUOTE) begin
      mode = SCAN_STRING;
    end else begin
      clear_scan();
      mode       = SCAN_WORD;
      digit_lead = is_digit(c);
      grow_word(c);
      add_token(sltsu_pkg::TYPE_END, c, 1'b1, 1'b0);
    end
  endtask

  task automatic scan_source_byte(input logic [7:0] c, input logic last_of_text);
    if (last_of_text) begin
      if (mode == SCAN_WORD) add_token(closed_word_type(), 8'd0, 1'b0, 1'b1);
      else if (mode == SCAN_STRING) add_token(sltsu_pkg::TYPE_STRING, 8'd0, 1'b0, 1'b1);
      add_token(sltsu_pkg::TYPE_END, 8'd0, 1'b0, 1'b1);
      clear_scan();
    end else if (mode == SCAN_STRING) begin
      if (c == sltsu_pkg::CHAR_QUOTE) begin
        add_token(sltsu_pkg::TYPE_STRING, 8'd0, 1'b0, 1'b1);
        clear_scan();
      end else begin
        add_token(sltsu_pkg::TYPE_STRING, c, 1'b1, 1'b0);
      end
    end else if (mode == SCAN_WORD && continues_word(c)) begin
      grow_word(c);
      add_token(sltsu_pkg::TYPE_END, c, 1'b1, 1'b0);
    end else begin
      // A byte that cannot continue the word closes it first.
      if (mode == SCAN_WORD) begin
        add_token(closed_word_type(), 8'd0, 1'b0, 1'b1);
        clear_scan();
      end
      open_token(c);
    end
  endtask

  task automatic check_result();
    sltsu_pkg::res_t want;
    if (expected_tokens.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected result: type %0d byte %02h has %0b last %0b", $realtime,
                 token_type, value_byte, has_byte, token_last);
    end else begin
      want = expected_tokens.pop_front();
      if (want.token_type !== token_type || want.value_byte !== value_byte ||
          want.has_byte !== has_byte || want.token_last !== token_last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] result %0d: expected %0d/%02h/%0b/%0b got %0d/%02h/%0b/%0b",
                   $realtime, match_count, want.token_type, want.value_byte,
                   want.has_byte, want.token_last, token_type, value_byte, has_byte,
                   token_last);
      end
      match_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) scan_source_byte(in_byte, end_of_input);
    end
    failures    <= fail_count;
    outstanding <= expected_tokens.size();
    checked     <= match_count;
  end

endmodule

// ===== sim/small_language_token_scanner_unit_test.sv =====
// Testbench top for the token scanner: clock, reset, source text stimulus,
// result-side stalls, watchdog and verdict. Depends on the scanner RTL, its
// package and small_language_token_scanner_unit_checker.

module small_language_token_scanner_unit_test;

  // Idle cycles with no handshake on either side before the run is called dead.
  localparam int WATCHDOG_LIMIT = 1000;
  // Source bytes to stop the random part at, directed part included.
  localparam int ITEM_TARGET = 1680;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       end_of_input = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [3:0] token_type;
  logic [7:0] value_byte;
  logic       has_byte;
  logic       token_last;

  int failures;
  int outstanding;
  int checked;

  int bytes_sent = 0;
  int texts_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  logic [1:0] rx_style = 2'd0;
  logic [5:0] rx_count = 6'd0;

  always #6 clk = ~clk;

  small_language_token_scanner_unit uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .empty        (empty),
    .pop          (pop),
    .token_type   (token_type),
    .value_byte   (value_byte),
    .has_byte     (has_byte),
    .token_last   (token_last)
  );

  small_language_token_scanner_unit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .empty        (empty),
    .pop          (pop),
    .token_type   (token_type),
    .value_byte   (value_byte),
    .has_byte     (has_byte),
    .token_last   (token_last),
    .failures     (failures),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  // Receiver: pick a new pop style each time rx_count wraps. Full-rate draining gives
  // stretches with no stalls; the sparse style backs results up into the
  // queue until full rises and the sender is held off.
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      rx_count <= 6'd0;
      rx_style <= 2'd0;
    end else begin
      rx_count <= rx_count + 6'd1;
      if (rx_count == 6'd63) rx_style <= 2'($urandom_range(0, 3));
      case (rx_style)
        2'd0: pop <= 1'b1;
        2'd1: pop <= 1'($urandom_range(0, 1));
        2'd2: pop <= (rx_count[2:0] == 3'd7);
        default: pop <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, outstanding);
      $display("** small_language_token_scanner_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one source item and hold it until the scanner takes it. Bursts
  // of random length are separated by random gaps with push low; long bursts
  // keep push high for stretches with no idling at all.
  task automatic send_item(input logic [7:0] b, input logic last_of_text);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                : $urandom_range(1, 12);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_byte      <= b;
    end_of_input <= last_of_text;
    do @(posedge clk); while (full);
    burst_left--;
    bytes_sent++;
    if (last_of_text) texts_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] random_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    if (r < 62) return 8'("A" + r - 36);
    return "_";
  endfunction

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(0, 6);
    return (r >= 5) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] random_punct();
    string marks;
    marks = "(){}:;,=";
    return marks[$urandom_range(0, 7)];
  endfunction

  // Close a word with a blank or punctuation most of the time; otherwise let
  // the next token run straight into it.
  task automatic maybe_separate();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) send_item(random_blank(), 1'b0);
    else if (r != 3) send_item(random_punct(), 1'b0);
  endtask

  // Exact keywords and near misses: cut short, run on, or one byte changed.
  task automatic send_keyword_like();
    string kw;
    int    k;
    int    how;
    int    cut;
    int    swap_at;
    k = $urandom_range(0, 2);
    case (k)
      0: kw = "let";
      1: kw = "fn";
      default: kw = "return";
    endcase
    how     = $urandom_range(0, 5);
    cut     = $urandom_range(1, kw.len() - 1);
    swap_at = $urandom_range(0, kw.len() - 1);
    for (int i = 0; i < kw.len(); i++) begin
      if (how == 3 && i == cut) break;
      if (how == 5 && i == swap_at) send_item(random_word_char(), 1'b0);
      else send_item(kw[i], 1'b0);
    end
    if (how == 4) begin
      repeat ($urandom_range(1, 3)) send_item(random_word_char(), 1'b0);
    end
    maybe_separate();
  endtask

  task automatic send_identifier();
    logic [7:0] first;
    int         r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      // Any byte outside blanks, punctuation and the quote starts a word.
      first = 8'($urandom_range(128, 255));
    end else if (r == 1) begin
      first = 8'($urandom_range(0, 8));
    end else if (r == 2) begin
      first = "_";
    end else begin
      first = ($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 25))
                                           : 8'("A" + $urandom_range(0, 25));
    end
    send_item(first, 1'b0);
    repeat ($urandom_range(0, 9)) send_item(random_word_char(), 1'b0);
    maybe_separate();
  endtask

  task automatic send_integer();
    send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 4) == 0) send_item(random_word_char(), 1'b0);
      else send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
    end
    maybe_separate();
  endtask

  // String body takes any byte but the quote; now and then leave it open so
  // the following bytes land inside it.
  task automatic send_string();
    logic [7:0] b;
    send_item("\"", 1'b0);
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == "\"") b = 8'h27;
      send_item(b, 1'b0);
    end
    if ($urandom_range(0, 9) != 0) send_item("\"", 1'b0);
  endtask

  task automatic send_random_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) send_keyword_like();
    else if (pick < 32) send_identifier();
    else if (pick < 42) send_integer();
    else if (pick < 54) send_string();
    else if (pick < 72) send_item(random_punct(), 1'b0);
    else if (pick < 80) repeat ($urandom_range(1, 3)) send_item(random_blank(), 1'b0);
    else if (pick < 92) send_item(8'($urandom_range(0, 255)), 1'b0);
    else send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed text: every keyword, every punctuation mark, an empty string,
    // an integer closed by a high byte that opens a new word, and end of input
    // closing that word.
    send_text("let fn(return){}:;,=\"\"9");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    // Unterminated string closed by end of input, then trailing whitespace
    // that must not leave an empty word behind.
    send_text("\"a");
    send_item(8'hA5, 1'b1);
    send_item(8'd13, 1'b0);
    send_item(8'h5A, 1'b1);

    while (bytes_sent < ITEM_TARGET) send_random_token();
    send_item(8'($urandom_range(0, 255)), 1'b1);
    push <= 1'b0;

    // Let the checker catch up on the last accepted byte, drain every due
    // result, then watch a little longer for anything extra.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Scanned %0d source bytes over %0d texts with random bursts and stalls;",
             bytes_sent, texts_sent);
    $display("%0d token results compared, %0d failures.", checked, failures);
    if (failures == 0) begin
      $display("** small_language_token_scanner_unit: PASSED **");
    end else begin
      $display("** small_language_token_scanner_unit: FAILED **");
    end
    $finish;
  end

endmodule
